// ===== rtl/lmbl_pkg.sv =====
`default_nettype none

package lmbl_pkg;

    // Link mode codes as they appear on the result.
    localparam logic [1:0] MODE_UNCONNECTED = 2'd0;
    localparam logic [1:0] MODE_CONNECTED   = 2'd1;
    localparam logic [1:0] MODE_PAIRING     = 2'd2;

    // Configuration register indexes.
    localparam logic [1:0] REG_SHUTDOWN_LIMIT  = 2'd0;
    localparam logic [1:0] REG_PAIRING_LIMIT   = 2'd1;
    localparam logic [1:0] REG_HOLD_LIMIT      = 2'd2;
    localparam logic [1:0] REG_LED_PERIOD_LAST = 2'd3;

    localparam int CfgAddrWidth = 4;
    localparam int CfgDataWidth = 32;

    // Reset values of the configuration registers.
    localparam logic [15:0] SHUTDOWN_LIMIT_RST  = 16'd18000;
    localparam logic [15:0] PAIRING_LIMIT_RST   = 16'd30000;
    localparam logic [7:0]  HOLD_LIMIT_RST      = 8'd100;
    localparam logic [9:0]  LED_PERIOD_LAST_RST = 10'd300;

    // Saturation points of the counters.
    localparam logic [15:0] TICK_MAX = 16'hFFFF;
    localparam logic [7:0]  HOLD_MAX = 8'hFF;

    // LED pattern: a short flash at the start of each cycle, a second flash
    // when unconnected, and a fast blink of period six while pairing.
    localparam logic [9:0] FLASH_END       = 10'd3;
    localparam logic [9:0] SECOND_FIRST    = 10'd20;
    localparam logic [9:0] SECOND_END      = 10'd23;
    localparam logic [2:0] BLINK_LAST      = 3'd5;
    localparam logic [2:0] BLINK_ON_END    = 3'd3;

    typedef struct packed {
        logic [15:0] shutdown_limit;
        logic [15:0] pairing_limit;
        logic [7:0]  hold_limit;
        logic [9:0]  led_period_last;
    } t_cfg;

    typedef struct packed {
        logic link_up;
        logic play_down;
        logic menu_down;
        logic middle_down;
    } t_btn;

    typedef struct packed {
        logic [1:0]  mode;
        logic        open_flag;
        logic [15:0] idle_ticks;
        logic [15:0] pair_ticks;
        logic [7:0]  hold_ticks;
        logic [9:0]  blink_phase;
        logic [2:0]  blink_mod6;
    } t_state;

    typedef struct packed {
        logic       led_lit;
        logic [1:0] link_mode;
        logic       accept_new_peers;
        logic       drop_link;
        logic       power_down;
    } t_res;

endpackage

`default_nettype wire

// ===== rtl/lmbl_cfg.sv =====
`default_nettype none

module lmbl_cfg (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                psel,
    input  wire logic                                penable,
    input  wire logic                                pwrite,
    input  wire logic [lmbl_pkg::CfgAddrWidth-1:0]   paddr,
    input  wire logic [lmbl_pkg::CfgDataWidth-1:0]   pwdata,
    output logic      [lmbl_pkg::CfgDataWidth-1:0]   prdata,
    output logic                                     pready,
    output lmbl_pkg::t_cfg                           o_cfg
);

    lmbl_pkg::t_cfg r_cfg;
    logic           w_wr;
    logic [1:0]     w_idx;

    assign pready = 1'b1;
    assign w_idx  = paddr[3:2];
    assign w_wr   = psel & penable & pwrite & pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.shutdown_limit  <= lmbl_pkg::SHUTDOWN_LIMIT_RST;
            r_cfg.pairing_limit   <= lmbl_pkg::PAIRING_LIMIT_RST;
            r_cfg.hold_limit      <= lmbl_pkg::HOLD_LIMIT_RST;
            r_cfg.led_period_last <= lmbl_pkg::LED_PERIOD_LAST_RST;
        end else if (w_wr) begin
            unique case (w_idx)
                lmbl_pkg::REG_SHUTDOWN_LIMIT:  r_cfg.shutdown_limit  <= pwdata[15:0];
                lmbl_pkg::REG_PAIRING_LIMIT:   r_cfg.pairing_limit   <= pwdata[15:0];
                lmbl_pkg::REG_HOLD_LIMIT:      r_cfg.hold_limit      <= pwdata[7:0];
                lmbl_pkg::REG_LED_PERIOD_LAST: r_cfg.led_period_last <= pwdata[9:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (w_idx)
            lmbl_pkg::REG_SHUTDOWN_LIMIT:  prdata = {16'd0, r_cfg.shutdown_limit};
            lmbl_pkg::REG_PAIRING_LIMIT:   prdata = {16'd0, r_cfg.pairing_limit};
            lmbl_pkg::REG_HOLD_LIMIT:      prdata = {24'd0, r_cfg.hold_limit};
            lmbl_pkg::REG_LED_PERIOD_LAST: prdata = {22'd0, r_cfg.led_period_last};
            default:                       prdata = '0;
        endcase
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

// ===== rtl/lmbl_step.sv =====
`default_nettype none

module lmbl_step (
    input  wire lmbl_pkg::t_cfg   i_cfg,
    input  wire lmbl_pkg::t_btn   i_btn,
    input  wire lmbl_pkg::t_state i_state,
    output lmbl_pkg::t_state      o_state,
    output lmbl_pkg::t_res        o_res
);

    logic [1:0]  w_mode_lnk;
    logic        w_open_lnk;
    logic [15:0] w_idle_lnk;
    logic [15:0] w_pair_lnk;
    logic        w_pdown;
    logic        w_led;
    logic [10:0] w_phase_inc;
    logic        w_wrap;
    logic        w_hold_met;
    logic        w_menu_combo;
    logic        w_play_combo;

    // Link mode update from the link flag and the two timeouts.
    always_comb begin
        w_mode_lnk = i_state.mode;
        w_open_lnk = i_state.open_flag;
        w_idle_lnk = i_state.idle_ticks;
        w_pair_lnk = i_state.pair_ticks;
        w_pdown    = 1'b0;
        if (i_btn.link_up && i_state.mode != lmbl_pkg::MODE_PAIRING) begin
            w_idle_lnk = '0;
            w_open_lnk = 1'b0;
            w_mode_lnk = lmbl_pkg::MODE_CONNECTED;
        end else if (i_state.mode == lmbl_pkg::MODE_PAIRING) begin
            if (i_state.pair_ticks != lmbl_pkg::TICK_MAX) begin
                w_pair_lnk = i_state.pair_ticks + 16'd1;
            end
            if (w_pair_lnk > i_cfg.pairing_limit) begin
                w_open_lnk = 1'b0;
                w_mode_lnk = lmbl_pkg::MODE_UNCONNECTED;
            end
        end else begin
            w_mode_lnk = lmbl_pkg::MODE_UNCONNECTED;
            if (i_state.idle_ticks != lmbl_pkg::TICK_MAX) begin
                w_idle_lnk = i_state.idle_ticks + 16'd1;
            end
            w_pdown = (w_idle_lnk > i_cfg.shutdown_limit);
        end
    end

    // LED level from the phase, using the mode after the link update.
    assign w_led = (i_state.blink_phase < lmbl_pkg::FLASH_END)
        || (i_state.blink_phase >= lmbl_pkg::SECOND_FIRST
            && i_state.blink_phase < lmbl_pkg::SECOND_END
            && w_mode_lnk == lmbl_pkg::MODE_UNCONNECTED)
        || (i_state.blink_mod6 < lmbl_pkg::BLINK_ON_END
            && w_mode_lnk == lmbl_pkg::MODE_PAIRING);

    assign w_phase_inc = {1'b0, i_state.blink_phase} + 11'd1;
    assign w_wrap      = (w_phase_inc > {1'b0, i_cfg.led_period_last});

    assign w_hold_met   = (i_state.hold_ticks > i_cfg.hold_limit);
    assign w_menu_combo = i_btn.menu_down & i_btn.middle_down & ~i_btn.play_down
                        & (w_mode_lnk == lmbl_pkg::MODE_UNCONNECTED);
    assign w_play_combo = i_btn.play_down & i_btn.middle_down & ~i_btn.menu_down
                        & (w_mode_lnk != lmbl_pkg::MODE_PAIRING);

    // Held button combinations act last.
    always_comb begin
        o_state.mode       = w_mode_lnk;
        o_state.open_flag  = w_open_lnk;
        o_state.idle_ticks = w_idle_lnk;
        o_state.pair_ticks = w_pair_lnk;
        o_state.hold_ticks = i_state.hold_ticks;
        o_res.drop_link    = 1'b0;
        if (w_menu_combo) begin
            if (w_hold_met) begin
                o_state.idle_ticks = '0;
            end else if (i_state.hold_ticks != lmbl_pkg::HOLD_MAX) begin
                o_state.hold_ticks = i_state.hold_ticks + 8'd1;
            end
        end else if (w_play_combo) begin
            if (w_hold_met) begin
                o_state.mode       = lmbl_pkg::MODE_PAIRING;
                o_state.open_flag  = 1'b1;
                o_state.pair_ticks = '0;
                o_res.drop_link    = 1'b1;
            end else if (i_state.hold_ticks != lmbl_pkg::HOLD_MAX) begin
                o_state.hold_ticks = i_state.hold_ticks + 8'd1;
            end
        end else begin
            o_state.hold_ticks = '0;
        end

        if (w_wrap) begin
            o_state.blink_phase = '0;
            o_state.blink_mod6  = '0;
        end else begin
            o_state.blink_phase = w_phase_inc[9:0];
            o_state.blink_mod6  = (i_state.blink_mod6 == lmbl_pkg::BLINK_LAST)
                                ? 3'd0 : i_state.blink_mod6 + 3'd1;
        end

        o_res.led_lit          = w_led;
        o_res.link_mode        = o_state.mode;
        o_res.accept_new_peers = o_state.open_flag;
        o_res.power_down       = w_pdown;
    end

endmodule

`default_nettype wire

// ===== rtl/link_mode_button_led_controller_top.sv =====
// An accepted input request passes through the input register and then the
// result register before its result request is offered.
// Throughput: one tick per cycle; the input and result registers stall only when
// the result side holds off.
// Reset: synchronous, active low on i_rst_n; the mode, counters and LED phase
// return to zero and the configuration registers to their defaults.
`default_nettype none

module link_mode_button_led_controller_top (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    // Configuration port
    input  wire logic                                psel,
    input  wire logic                                penable,
    input  wire logic                                pwrite,
    input  wire logic [lmbl_pkg::CfgAddrWidth-1:0]   paddr,
    input  wire logic [lmbl_pkg::CfgDataWidth-1:0]   pwdata,
    output logic      [lmbl_pkg::CfgDataWidth-1:0]   prdata,
    output logic                                     pready,
    // Tick input channel
    input  wire logic                                i_in_valid,
    output logic                                     o_in_ready,
    input  wire logic                                i_link_up,
    input  wire logic                                i_play_down,
    input  wire logic                                i_menu_down,
    input  wire logic                                i_middle_down,
    // Result channel
    output logic                                     o_out_valid,
    input  wire logic                                i_out_ready,
    output logic                                     o_led_lit,
    output logic      [1:0]                          o_link_mode,
    output logic                                     o_accept_new_peers,
    output logic                                     o_drop_link,
    output logic                                     o_power_down
);

    // The configuration registers live in their own block and feed the step logic
    // directly; the user must write them only while no tick is in flight (unenforced).
    lmbl_pkg::t_cfg   w_cfg;
    lmbl_pkg::t_btn   r_in;
    logic             r_in_valid;
    lmbl_pkg::t_state r_state;
    lmbl_pkg::t_state n_state;
    lmbl_pkg::t_res   r_out;
    lmbl_pkg::t_res   n_out;
    logic             r_out_valid;
    logic             w_advance;

    lmbl_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    // A tick moves from the input register into the result register whenever
    // the result register is empty or its request is being taken in the same
    // cycle. The controller state advances at exactly that edge, so each tick
    // sees the state left by the one before it.
    assign w_advance  = r_in_valid & (~r_out_valid | i_out_ready);
    assign o_in_ready = ~r_in_valid | w_advance;

    lmbl_step u_step (
        .i_cfg   (w_cfg),
        .i_btn   (r_in),
        .i_state (r_state),
        .o_state (n_state),
        .o_res   (n_out)
    );

    // Control flags of the two pipeline registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end
            if (w_advance) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Controller state: mode, pairing flag, counters and LED phase.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '0;
        end else if (w_advance) begin
            r_state <= n_state;
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_in.link_up     <= i_link_up;
            r_in.play_down   <= i_play_down;
            r_in.menu_down   <= i_menu_down;
            r_in.middle_down <= i_middle_down;
        end
        if (w_advance) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid        = r_out_valid;
    assign o_led_lit          = r_out.led_lit;
    assign o_link_mode        = r_out.link_mode;
    assign o_accept_new_peers = r_out.accept_new_peers;
    assign o_drop_link        = r_out.drop_link;
    assign o_power_down       = r_out.power_down;

`ifndef NO_ASSERTIONS
    // A disconnect request only ever comes with the switch into open pairing.
    a_drop_pairing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_drop_link) |->
            (o_link_mode == lmbl_pkg::MODE_PAIRING && o_accept_new_peers))
        else $error("drop_link without pairing mode");

    // Shutdown is flagged only from the unconnected branch.
    a_pdown_unconn: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_power_down && !o_drop_link) |->
            (o_link_mode == lmbl_pkg::MODE_UNCONNECTED))
        else $error("power_down outside unconnected mode");

    // A tick held in the input register is not lost while the result side stalls.
    a_in_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !w_advance) |=> r_in_valid)
        else $error("input tick dropped during stall");
`endif

endmodule

`default_nettype wire

// ===== test/lmbl_tick_checker.sv =====
`timescale 1ns / 1ps

module lmbl_tick_checker (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_psel,
    input  logic                                  i_penable,
    input  logic                                  i_pwrite,
    input  logic [lmbl_pkg::CfgAddrWidth-1:0]     i_paddr,
    input  logic [lmbl_pkg::CfgDataWidth-1:0]     i_pwdata,
    input  logic                                  i_pready,
    input  logic                                  i_in_valid,
    input  logic                                  i_in_ready,
    input  logic                                  i_link_up,
    input  logic                                  i_play_down,
    input  logic                                  i_menu_down,
    input  logic                                  i_middle_down,
    input  logic                                  i_out_valid,
    input  logic                                  i_out_ready,
    input  logic                                  i_led_lit,
    input  logic [1:0]                            i_link_mode,
    input  logic                                  i_accept_new_peers,
    input  logic                                  i_drop_link,
    input  logic                                  i_power_down,
    output int                                    o_fail_count,
    output int                                    o_outstanding
);

    localparam int BLINK_PERIOD = 6;
    localparam int PHASE_MAX    = 1023;

    lmbl_pkg::t_cfg cfg;
    logic [1:0]     mode_now;
    logic           open_now;
    logic [15:0]    idle_cnt;
    logic [15:0]    pair_cnt;
    logic [7:0]     hold_cnt;
    logic [9:0]     phase_cnt;
    lmbl_pkg::t_res tick_results_q[$];
    lmbl_pkg::t_res predicted;
    lmbl_pkg::t_res want;
    lmbl_pkg::t_btn tick;
    int             fails = 0;

    // Advances the controller by one tick and gives the result it should report.
    task automatic step_controller(input lmbl_pkg::t_btn btn, output lmbl_pkg::t_res res);
        logic led;
        logic drop;
        logic pdown;
        int   nxt;
        led   = 1'b0;
        drop  = 1'b0;
        pdown = 1'b0;

        if (btn.link_up && mode_now != lmbl_pkg::MODE_PAIRING) begin
            idle_cnt = '0;
            open_now = 1'b0;
            mode_now = lmbl_pkg::MODE_CONNECTED;
        end else if (mode_now == lmbl_pkg::MODE_PAIRING) begin
            if (pair_cnt != lmbl_pkg::TICK_MAX) pair_cnt++;
            if (pair_cnt > cfg.pairing_limit) begin
                open_now = 1'b0;
                mode_now = lmbl_pkg::MODE_UNCONNECTED;
            end
        end else begin
            mode_now = lmbl_pkg::MODE_UNCONNECTED;
            if (idle_cnt != lmbl_pkg::TICK_MAX) idle_cnt++;
            if (idle_cnt > cfg.shutdown_limit) pdown = 1'b1;
        end

        if (phase_cnt < lmbl_pkg::FLASH_END) begin
            led = 1'b1;
        end else if (phase_cnt >= lmbl_pkg::SECOND_FIRST && phase_cnt < lmbl_pkg::SECOND_END
                     && mode_now == lmbl_pkg::MODE_UNCONNECTED) begin
            led = 1'b1;
        end else if ((int'(phase_cnt) % BLINK_PERIOD) < int'(lmbl_pkg::BLINK_ON_END)
                     && mode_now == lmbl_pkg::MODE_PAIRING) begin
            led = 1'b1;
        end

        nxt = int'(phase_cnt) + 1;
        if (nxt > int'(cfg.led_period_last) || nxt > PHASE_MAX) phase_cnt = '0;
        else phase_cnt = 10'(nxt);

        if (btn.menu_down && btn.middle_down && !btn.play_down
            && mode_now == lmbl_pkg::MODE_UNCONNECTED) begin
            if (hold_cnt > cfg.hold_limit) idle_cnt = '0;
            else if (hold_cnt != lmbl_pkg::HOLD_MAX) hold_cnt++;
        end else if (btn.play_down && btn.middle_down && !btn.menu_down
                     && mode_now != lmbl_pkg::MODE_PAIRING) begin
            if (hold_cnt > cfg.hold_limit) begin
                mode_now = lmbl_pkg::MODE_PAIRING;
                open_now = 1'b1;
                pair_cnt = '0;
                drop     = 1'b1;
            end else if (hold_cnt != lmbl_pkg::HOLD_MAX) begin
                hold_cnt++;
            end
        end else begin
            hold_cnt = '0;
        end

        res.led_lit          = led;
        res.link_mode        = mode_now;
        res.accept_new_peers = open_now;
        res.drop_link        = drop;
        res.power_down       = pdown;
    endtask

    task automatic check_field(input string name, input logic [1:0] exp_val,
                               input logic [1:0] got_val);
        if (got_val !== exp_val) begin
            $error("%s: expected %0d, got %0d", name, exp_val, got_val);
            fails++;
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            cfg.shutdown_limit  = lmbl_pkg::SHUTDOWN_LIMIT_RST;
            cfg.pairing_limit   = lmbl_pkg::PAIRING_LIMIT_RST;
            cfg.hold_limit      = lmbl_pkg::HOLD_LIMIT_RST;
            cfg.led_period_last = lmbl_pkg::LED_PERIOD_LAST_RST;
            mode_now  = lmbl_pkg::MODE_UNCONNECTED;
            open_now  = 1'b0;
            idle_cnt  = '0;
            pair_cnt  = '0;
            hold_cnt  = '0;
            phase_cnt = '0;
            tick_results_q.delete();
        end else begin
            if (i_psel && i_penable && i_pwrite && i_pready) begin
                case (i_paddr[3:2])
                    lmbl_pkg::REG_SHUTDOWN_LIMIT:  cfg.shutdown_limit  = i_pwdata[15:0];
                    lmbl_pkg::REG_PAIRING_LIMIT:   cfg.pairing_limit   = i_pwdata[15:0];
                    lmbl_pkg::REG_HOLD_LIMIT:      cfg.hold_limit      = i_pwdata[7:0];
                    lmbl_pkg::REG_LED_PERIOD_LAST: cfg.led_period_last = i_pwdata[9:0];
                    default: ;
                endcase
            end

            // Results leave only after their tick has been registered, so compare first.
            if (i_out_valid && i_out_ready) begin
                if (tick_results_q.size() == 0) begin
                    $error("result request arrived with no tick outstanding");
                    fails++;
                end else begin
                    want = tick_results_q.pop_front();
                    check_field("led_lit", want.led_lit, i_led_lit);
                    check_field("link_mode", want.link_mode, i_link_mode);
                    check_field("accept_new_peers", want.accept_new_peers,
                                i_accept_new_peers);
                    check_field("drop_link", want.drop_link, i_drop_link);
                    check_field("power_down", want.power_down, i_power_down);
                end
            end

            if (i_in_valid && i_in_ready) begin
                tick.link_up     = i_link_up;
                tick.play_down   = i_play_down;
                tick.menu_down   = i_menu_down;
                tick.middle_down = i_middle_down;
                step_controller(tick, predicted);
                tick_results_q.push_back(predicted);
            end
        end
        o_fail_count  <= fails;
        o_outstanding <= tick_results_q.size();
    end

endmodule

// ===== test/tb.sv =====
`timescale 1ns / 1ps

module tb;

    // Cycles allowed after the last result for any stray request to show up.
    localparam int SETTLE_CYCLES = 8;
    // Length of the one long hold-off on the result side.
    localparam int HOLD_OFF_CYCLES = 60;
    // Upper bound on the run time in nanoseconds, many times the slowest correct run.
    localparam int RUN_LIMIT_NS = 4_000_000;

    typedef enum int {
        EP_LINKED,
        EP_IDLE,
        EP_MENU_HOLD,
        EP_PLAY_HOLD,
        EP_NOISE
    } t_episode;

    logic                              i_clk;
    logic                              i_rst_n;
    logic                              psel;
    logic                              penable;
    logic                              pwrite;
    logic [lmbl_pkg::CfgAddrWidth-1:0] paddr;
    logic [lmbl_pkg::CfgDataWidth-1:0] pwdata;
    logic [lmbl_pkg::CfgDataWidth-1:0] prdata;
    logic                              pready;
    logic                              i_in_valid;
    logic                              o_in_ready;
    logic                              i_link_up;
    logic                              i_play_down;
    logic                              i_menu_down;
    logic                              i_middle_down;
    logic                              o_out_valid;
    logic                              i_out_ready;
    logic                              o_led_lit;
    logic [1:0]                        o_link_mode;
    logic                              o_accept_new_peers;
    logic                              o_drop_link;
    logic                              o_power_down;

    int fail_count;
    int outstanding;

    // Number of tick requests accepted so far; only the sender writes it.
    int sent = 0;

    // The limits currently programmed, used to size the stimulus episodes.
    int cur_shut;
    int cur_pair;
    int cur_hold;

    // Raised once by the sender to ask the result side for its long hold-off.
    bit squeeze_go   = 1'b0;
    bit squeeze_done = 1'b0;

    link_mode_button_led_controller_top uut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .psel               (psel),
        .penable            (penable),
        .pwrite             (pwrite),
        .paddr              (paddr),
        .pwdata             (pwdata),
        .prdata             (prdata),
        .pready             (pready),
        .i_in_valid         (i_in_valid),
        .o_in_ready         (o_in_ready),
        .i_link_up          (i_link_up),
        .i_play_down        (i_play_down),
        .i_menu_down        (i_menu_down),
        .i_middle_down      (i_middle_down),
        .o_out_valid        (o_out_valid),
        .i_out_ready        (i_out_ready),
        .o_led_lit          (o_led_lit),
        .o_link_mode        (o_link_mode),
        .o_accept_new_peers (o_accept_new_peers),
        .o_drop_link        (o_drop_link),
        .o_power_down       (o_power_down)
    );

    // The checker sits beside the block, watching both channels and the
    // configuration port, and reports how many mismatches it has seen and how
    // many results are still owed.
    lmbl_tick_checker u_checker (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_psel             (psel),
        .i_penable          (penable),
        .i_pwrite           (pwrite),
        .i_paddr            (paddr),
        .i_pwdata           (pwdata),
        .i_pready           (pready),
        .i_in_valid         (i_in_valid),
        .i_in_ready         (o_in_ready),
        .i_link_up          (i_link_up),
        .i_play_down        (i_play_down),
        .i_menu_down        (i_menu_down),
        .i_middle_down      (i_middle_down),
        .i_out_valid        (o_out_valid),
        .i_out_ready        (i_out_ready),
        .i_led_lit          (o_led_lit),
        .i_link_mode        (o_link_mode),
        .i_accept_new_peers (o_accept_new_peers),
        .i_drop_link        (o_drop_link),
        .i_power_down       (o_power_down),
        .o_fail_count       (fail_count),
        .o_outstanding      (outstanding)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // A fixed upper bound on the whole run, in case the block locks up.
    initial begin
        #(RUN_LIMIT_NS);
        $display("FAIL");
        $finish;
    end

    function automatic lmbl_pkg::t_btn make_tick(input logic link, input logic play,
                                                 input logic menu, input logic middle);
        lmbl_pkg::t_btn btn;
        btn.link_up     = link;
        btn.play_down   = play;
        btn.menu_down   = menu;
        btn.middle_down = middle;
        return btn;
    endfunction

    // In a quiet stretch the sender offers back-to-back requests; otherwise it
    // waits a gap drawn at random before each one.
    function automatic int draw_gap(input bit quiet);
        return quiet ? 0 : int'($urandom_range(0, 9));
    endfunction

    // Offers one tick request and waits for the block to accept it. Valid is
    // only dropped when a gap is wanted, so back-to-back requests keep it high.
    task automatic send_tick(input lmbl_pkg::t_btn btn, input int gap);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_link_up     <= btn.link_up;
        i_play_down   <= btn.play_down;
        i_menu_down   <= btn.menu_down;
        i_middle_down <= btn.middle_down;
        do @(posedge i_clk); while (!o_in_ready);
        sent++;
    endtask

    // Stops offering ticks and waits until every result has come back, then
    // for SETTLE_CYCLES more so that nothing is still in flight.
    task automatic drain_block();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (outstanding != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // A register write: a setup phase, then an access phase that completes
    // when pready is seen high. An idle phase follows, so that a following
    // write never re-raises psel in the step in which this one lowers it.
    task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
    endtask

    // Programs all four limits. The bits above each register's width are filled
    // with noise, since the block is expected to ignore them.
    task automatic set_limits(input int shut, input int pair, input int hold,
                              input int led_last);
        logic [31:0] junk;
        junk = $urandom();
        write_reg(lmbl_pkg::REG_SHUTDOWN_LIMIT, {junk[31:16], 16'(shut)});
        junk = $urandom();
        write_reg(lmbl_pkg::REG_PAIRING_LIMIT, {junk[31:16], 16'(pair)});
        junk = $urandom();
        write_reg(lmbl_pkg::REG_HOLD_LIMIT, {junk[31:8], 8'(hold)});
        junk = $urandom();
        write_reg(lmbl_pkg::REG_LED_PERIOD_LAST, {junk[31:10], 10'(led_last)});
        cur_shut = shut;
        cur_pair = pair;
        cur_hold = hold;
    endtask

    // One episode of ticks with a purpose: a connected stretch, an unconnected
    // or pairing stretch that can reach small timeouts, a held button
    // combination around the hold limit (sometimes just too short), or noise.
    task automatic run_episode();
        t_episode       kind;
        int             pick;
        int             span;
        int             count;
        int             k;
        bit             quiet;
        lmbl_pkg::t_btn btn;
        pick  = $urandom_range(0, 9);
        quiet = ($urandom_range(0, 3) == 0);
        span  = ((cur_shut > cur_pair) ? cur_shut : cur_pair) + 4;
        if (span > 30) span = 30;
        if (pick < 2) kind = EP_LINKED;
        else if (pick < 4) kind = EP_IDLE;
        else if (pick < 6) kind = EP_MENU_HOLD;
        else if (pick < 8) kind = EP_PLAY_HOLD;
        else kind = EP_NOISE;

        case (kind)
            EP_LINKED, EP_IDLE: count = $urandom_range(1, span);
            EP_MENU_HOLD, EP_PLAY_HOLD: count = cur_hold + $urandom_range(1, 5);
            default: count = $urandom_range(1, 8);
        endcase

        for (k = 0; k < count; k++) begin
            btn = 4'($urandom_range(0, 15));
            case (kind)
                EP_LINKED: btn.link_up = 1'b1;
                EP_IDLE: btn = make_tick(1'b0, 1'b0, 1'b0, 1'b0);
                EP_MENU_HOLD: btn = make_tick($urandom_range(0, 15) == 0,
                                              1'b0, 1'b1, 1'b1);
                EP_PLAY_HOLD: btn = make_tick($urandom_range(0, 3) == 0,
                                              1'b1, 1'b0, 1'b1);
                default: ;
            endcase
            send_tick(btn, draw_gap(quiet));
        end
    endtask

    task automatic run_phase(input int budget);
        int first;
        first = sent;
        while (sent - first < budget) run_episode();
    endtask

    // Result side: before each result it holds off for a random number of
    // cycles, apart from quiet stretches in which it takes every result at
    // once. When the sender asks for it, it holds off once for a long stretch
    // so that the block backs up and stalls its tick input.
    initial begin
        int stall;
        bit quiet;
        quiet = 1'b0;
        i_out_ready <= 1'b0;
        wait (i_rst_n === 1'b1);
        @(posedge i_clk);
        forever begin
            if (squeeze_go && !squeeze_done) begin
                i_out_ready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge i_clk);
                squeeze_done = 1'b1;
            end else begin
                stall = draw_gap(quiet);
                if (stall > 0) begin
                    i_out_ready <= 1'b0;
                    repeat (stall) @(posedge i_clk);
                end
            end
            i_out_ready <= 1'b1;
            do @(posedge i_clk); while (!o_out_valid);
            if ($urandom_range(0, 29) == 0) quiet = !quiet;
        end
    end

    // Stimulus and verdict.
    initial begin
        int k;
        i_rst_n       <= 1'b0;
        psel          <= 1'b0;
        penable       <= 1'b0;
        pwrite        <= 1'b0;
        paddr         <= '0;
        pwdata        <= '0;
        i_in_valid    <= 1'b0;
        i_link_up     <= 1'b0;
        i_play_down   <= 1'b0;
        i_menu_down   <= 1'b0;
        i_middle_down <= 1'b0;
        cur_shut = lmbl_pkg::SHUTDOWN_LIMIT_RST;
        cur_pair = lmbl_pkg::PAIRING_LIMIT_RST;
        cur_hold = lmbl_pkg::HOLD_LIMIT_RST;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Every combination of the link flag and the three buttons, with the
        // limits at their reset values. The last one leaves the link connected.
        for (k = 0; k < 16; k++) send_tick(4'(k), draw_gap(1'b0));
        drain_block();

        // Tight limits and an LED period shorter than the second flash, so
        // that the timeouts and both combinations act within a few ticks.
        set_limits(0, 1, 1, 5);
        // Dropping the link with a zero shutdown limit flags power-down at once.
        send_tick(make_tick(1'b0, 1'b0, 1'b0, 1'b0), draw_gap(1'b0));
        // Play and middle held past the hold limit start pairing and request a
        // disconnect.
        repeat (3) send_tick(make_tick(1'b0, 1'b1, 1'b0, 1'b1), draw_gap(1'b0));
        // While pairing the link flag is ignored until the pairing timeout
        // passes and the mode falls back to unconnected.
        repeat (2) send_tick(make_tick(1'b1, 1'b1, 1'b1, 1'b1), draw_gap(1'b0));
        send_tick(make_tick(1'b0, 1'b0, 1'b0, 1'b0), draw_gap(1'b0));
        // Menu and middle held long enough re-arm the shutdown timeout.
        repeat (3) send_tick(make_tick(1'b0, 1'b0, 1'b1, 1'b1), draw_gap(1'b0));
        drain_block();

        // Moderate limits, starting with a burst of requests while the result
        // side holds off.
        set_limits(20, 30, 5, 40);
        squeeze_go = 1'b1;
        repeat (30) send_tick(4'($urandom_range(0, 15)), 0);
        run_phase(170);
        drain_block();

        // Every limit at its lowest, with a zero LED period.
        set_limits(0, 0, 0, 0);
        run_phase(150);
        drain_block();

        // Every limit at its highest: the timeouts never expire and the hold
        // counter saturates without ever acting.
        set_limits(16'hFFFF, 16'hFFFF, 8'hFF, 10'h3FF);
        run_phase(200);
        drain_block();

        // Small limits with the shortest LED period the pattern is meant for.
        set_limits(3, 2, 1, 23);
        run_phase(150);

        repeat (3) begin
            drain_block();
            set_limits($urandom_range(0, 60), $urandom_range(0, 60),
                       $urandom_range(0, 12), $urandom_range(0, 1023));
            run_phase(150);
        end

        // Wait for every result, then a little longer to catch stray requests.
        drain_block();

        if (fail_count == 0 && outstanding == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
